// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the float sign/minmax/compare/class unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst_n is low.
`define FSMCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never hold while out of reset.
`define FSMCC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/fsmcc_pkg.sv -----
// Package: word types, command codes and constants of the float sign/minmax/compare/class unit.
`timescale 1ns / 1ps

package fsmcc_pkg;

  // Register count per file; must stay a power of two (index reduction truncates).
  localparam int REG_COUNT = 32;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int INDEX_W   = 5;   // width of the index fields on the ports
  localparam int DATA_W    = 32;

  localparam logic [DATA_W-1:0] MAG_MASK  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [DATA_W-1:0] CANON_NAN = 32'h7FC0_0000;

  typedef enum logic [2:0] {
    CMD_SGNJ      = 3'd0,
    CMD_MINMAX    = 3'd1,
    CMD_CMP       = 3'd2,
    CMD_CLASS     = 3'd3,
    CMD_MV_F2I    = 3'd4,
    CMD_MV_I2F    = 3'd5,
    CMD_LOAD_INT  = 3'd6,
    CMD_LOAD_FLT  = 3'd7
  } cmd_e;

  // func variants
  localparam logic [1:0] FN_SGNJ  = 2'd0;
  localparam logic [1:0] FN_SGNJN = 2'd1;
  localparam logic [1:0] FN_SGNJX = 2'd2;
  localparam logic [1:0] FN_MIN   = 2'd0;
  localparam logic [1:0] FN_MAX   = 2'd1;
  localparam logic [1:0] FN_LE    = 2'd0;
  localparam logic [1:0] FN_LT    = 2'd1;
  localparam logic [1:0] FN_EQ    = 2'd2;

  typedef struct packed {
    cmd_e               cmd;
    logic [1:0]         func;
    logic [INDEX_W-1:0] dest_index;
    logic [INDEX_W-1:0] src1_index;
    logic [INDEX_W-1:0] src2_index;
    logic [DATA_W-1:0]  write_value;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]  result_value;
    logic               to_int_file;
    logic [INDEX_W-1:0] dest_echo;
    logic               bad_func;
  } out_word_t;

  // Register number reduced to the file depth.
  function automatic logic [IDX_W-1:0] reg_sel(input logic [INDEX_W-1:0] idx);
    reg_sel = idx[IDX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/fp_sign_minmax_compare_class_unit_core.sv -----
// Top level: command intake, register file read/write-back and result strobe.
`timescale 1ns / 1ps

// A word is taken at a rising edge with start high and busy low. busy is then high for
// exactly one cycle, while the register files return the operands; at the end of that
// cycle the destination register is written and the result is shown on out_word with
// out_valid high for exactly one cycle, which the receiver must take as it comes. A new
// word is taken only once busy is low again, after the registered file read and the
// execute and write-back of the last word, so every command sees all earlier writes.
// Both files read as zero after reset without any clearing pass.

`include "assert_macros.svh"

module fp_sign_minmax_compare_class_unit_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fsmcc_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output fsmcc_pkg::out_word_t out_word
);

  logic                         accept;
  logic                         exec_valid_r;
  logic                         exec_valid_nxt;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  fsmcc_pkg::in_word_t          op_r;
  fsmcc_pkg::out_word_t         out_word_r;
  fsmcc_pkg::out_word_t         res;
  logic [fsmcc_pkg::DATA_W-1:0] fa;
  logic [fsmcc_pkg::DATA_W-1:0] fb;
  logic [fsmcc_pkg::DATA_W-1:0] ia;
  logic                         wr_en;
  logic [fsmcc_pkg::IDX_W-1:0]  waddr;

  assign accept = start && !exec_valid_r;

  always_comb begin
    exec_valid_nxt = accept;
    out_valid_nxt  = exec_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      exec_valid_r <= exec_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_word;
    end
    if (exec_valid_r) begin
      out_word_r <= res;
    end
  end

  fsmcc_float_file u_float_file (
    .clk    (clk),
    .rst_n  (rst_n),
    .re     (accept),
    .raddr1 (fsmcc_pkg::reg_sel(in_word.src1_index)),
    .raddr2 (fsmcc_pkg::reg_sel(in_word.src2_index)),
    .rdata1 (fa),
    .rdata2 (fb),
    .we     (wr_en && !res.to_int_file),
    .waddr  (waddr),
    .wdata  (res.result_value)
  );

  fsmcc_int_file u_int_file (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (accept),
    .raddr (fsmcc_pkg::reg_sel(in_word.src1_index)),
    .rdata (ia),
    .we    (wr_en && res.to_int_file),
    .waddr (waddr),
    .wdata (res.result_value)
  );

  fsmcc_exec u_exec (
    .op  (op_r),
    .fa  (fa),
    .fb  (fb),
    .ia  (ia),
    .res (res)
  );

  // illegal variants write nothing
  assign wr_en = exec_valid_r && !res.bad_func;
  assign waddr = fsmcc_pkg::reg_sel(op_r.dest_index);

  assign busy      = exec_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `FSMCC_ASSERT(a_accept_busy, accept |=> busy, "accepted word did not raise busy")
  `FSMCC_ASSERT(a_busy_single, busy |=> !busy, "busy held longer than one cycle")
  `FSMCC_ASSERT(a_out_after_exec, out_valid |-> $past(busy), "result without execute cycle")
  `FSMCC_NEVER(a_bad_clean, out_valid && out_word.bad_func && (out_word.to_int_file || out_word.result_value != '0 || out_word.dest_echo != '0), "illegal variant with nonzero result")

endmodule

// ----- hw/rtl/fsmcc_float_file.sv -----
// Float register file: two registered read ports, one write port, valid bits for reset-to-zero.
`timescale 1ns / 1ps

module fsmcc_float_file (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   re,
  input  logic [fsmcc_pkg::IDX_W-1:0]            raddr1,
  input  logic [fsmcc_pkg::IDX_W-1:0]            raddr2,
  output logic [fsmcc_pkg::DATA_W-1:0]           rdata1,
  output logic [fsmcc_pkg::DATA_W-1:0]           rdata2,
  input  logic                                   we,
  input  logic [fsmcc_pkg::IDX_W-1:0]            waddr,
  input  logic [fsmcc_pkg::DATA_W-1:0]           wdata
);

  logic [fsmcc_pkg::DATA_W-1:0]    mem_r [fsmcc_pkg::REG_COUNT];
  logic [fsmcc_pkg::REG_COUNT-1:0] vld_r;
  logic [fsmcc_pkg::DATA_W-1:0]    rd1_r;
  logic [fsmcc_pkg::DATA_W-1:0]    rd2_r;
  logic                            hit1_r;
  logic                            hit2_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd1_r <= mem_r[raddr1];
      rd2_r <= mem_r[raddr2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      hit1_r <= 1'b0;
      hit2_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        hit1_r <= vld_r[raddr1];
        hit2_r <= vld_r[raddr2];
      end
    end
  end

  // never-written entries read as zero
  assign rdata1 = hit1_r ? rd1_r : '0;
  assign rdata2 = hit2_r ? rd2_r : '0;

endmodule

// ----- hw/rtl/fsmcc_int_file.sv -----
// Integer register file: one registered read port, one write port, valid bits for reset-to-zero.
`timescale 1ns / 1ps

module fsmcc_int_file (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         re,
  input  logic [fsmcc_pkg::IDX_W-1:0]  raddr,
  output logic [fsmcc_pkg::DATA_W-1:0] rdata,
  input  logic                         we,
  input  logic [fsmcc_pkg::IDX_W-1:0]  waddr,
  input  logic [fsmcc_pkg::DATA_W-1:0] wdata
);

  logic [fsmcc_pkg::DATA_W-1:0]    mem_r [fsmcc_pkg::REG_COUNT];
  logic [fsmcc_pkg::REG_COUNT-1:0] vld_r;
  logic [fsmcc_pkg::DATA_W-1:0]    rd_r;
  logic                            hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        hit_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = hit_r ? rd_r : '0;

endmodule

// ----- hw/rtl/fsmcc_exec.sv -----
// Execute logic: sign injection, min/max, compare, classify, moves on the operands read and immediate loads.
`timescale 1ns / 1ps

module fsmcc_exec (
  input  fsmcc_pkg::in_word_t          op,
  input  logic [fsmcc_pkg::DATA_W-1:0] fa,
  input  logic [fsmcc_pkg::DATA_W-1:0] fb,
  input  logic [fsmcc_pkg::DATA_W-1:0] ia,
  output fsmcc_pkg::out_word_t         res
);

  function automatic logic is_nan(input logic [fsmcc_pkg::DATA_W-1:0] v);
    is_nan = (&v[30:23]) && (|v[22:0]);
  endfunction

  // unsigned key ordering like the float value (non-NaN only)
  function automatic logic [fsmcc_pkg::DATA_W-1:0] order_key(
    input logic [fsmcc_pkg::DATA_W-1:0] v);
    order_key = v[31] ? ~v : (v | fsmcc_pkg::SIGN_MASK);
  endfunction

  function automatic logic [fsmcc_pkg::DATA_W-1:0] classify(
    input logic [fsmcc_pkg::DATA_W-1:0] v);
    logic neg;
    logic exp_ones;
    logic exp_zero;
    logic man_zero;
    neg      = v[31];
    exp_ones = &v[30:23];
    exp_zero = ~|v[30:23];
    man_zero = ~|v[22:0];
    classify = '0;
    if (exp_ones) begin
      if (man_zero) classify[neg ? 0 : 7] = 1'b1;
      else          classify[v[22] ? 9 : 8] = 1'b1;
    end else if (exp_zero) begin
      if (man_zero) classify[neg ? 3 : 4] = 1'b1;
      else          classify[neg ? 2 : 5] = 1'b1;
    end else begin
      classify[neg ? 1 : 6] = 1'b1;
    end
  endfunction

  logic                         nan_a;
  logic                         nan_b;
  logic                         a_lt;
  logic                         zeros;
  logic [fsmcc_pkg::DATA_W-1:0] ka;
  logic [fsmcc_pkg::DATA_W-1:0] kb;
  logic [fsmcc_pkg::DATA_W-1:0] value;
  logic                         to_int;
  logic                         bad;

  assign nan_a = is_nan(fa);
  assign nan_b = is_nan(fb);
  assign ka    = order_key(fa);
  assign kb    = order_key(fb);
  assign a_lt  = ka < kb;
  assign zeros = ((fa | fb) & fsmcc_pkg::MAG_MASK) == '0;

  always_comb begin
    value  = '0;
    to_int = 1'b0;
    bad    = 1'b0;
    unique case (op.cmd)
      fsmcc_pkg::CMD_SGNJ: begin
        case (op.func)
          fsmcc_pkg::FN_SGNJ:  value = {fb[31], fa[30:0]};
          fsmcc_pkg::FN_SGNJN: value = {~fb[31], fa[30:0]};
          fsmcc_pkg::FN_SGNJX: value = {fa[31] ^ fb[31], fa[30:0]};
          default:             bad = 1'b1;
        endcase
      end
      fsmcc_pkg::CMD_MINMAX: begin
        if (op.func != fsmcc_pkg::FN_MIN && op.func != fsmcc_pkg::FN_MAX) begin
          bad = 1'b1;
        end else if (nan_a && nan_b) begin
          value = fsmcc_pkg::CANON_NAN;
        end else if (nan_a) begin
          value = fb;
        end else if (nan_b) begin
          value = fa;
        end else if (op.func == fsmcc_pkg::FN_MIN) begin
          value = a_lt ? fa : fb;
        end else begin
          value = a_lt ? fb : fa;
        end
      end
      fsmcc_pkg::CMD_CMP: begin
        to_int = 1'b1;
        case (op.func)
          fsmcc_pkg::FN_LE: value[0] = !nan_a && !nan_b && (zeros || ka <= kb);
          fsmcc_pkg::FN_LT: value[0] = !nan_a && !nan_b && !zeros && a_lt;
          fsmcc_pkg::FN_EQ: value[0] = !nan_a && !nan_b && (zeros || fa == fb);
          default:          bad = 1'b1;
        endcase
      end
      fsmcc_pkg::CMD_CLASS: begin
        to_int = 1'b1;
        value  = classify(fa);
      end
      fsmcc_pkg::CMD_MV_F2I: begin
        to_int = 1'b1;
        value  = fa;
      end
      fsmcc_pkg::CMD_MV_I2F: begin
        value = ia;
      end
      fsmcc_pkg::CMD_LOAD_INT: begin
        to_int = 1'b1;
        value  = op.write_value;
      end
      fsmcc_pkg::CMD_LOAD_FLT: begin
        value = op.write_value;
      end
    endcase

    if (bad) begin
      res = '0;
      res.bad_func = 1'b1;
    end else begin
      res.result_value = value;
      res.to_int_file  = to_int;
      res.dest_echo    = fsmcc_pkg::INDEX_W'(fsmcc_pkg::reg_sel(op.dest_index));
      res.bad_func     = 1'b0;
    end
  end

endmodule
